// ----- rtl/feft_pkg.sv -----
// shared types, codes and defaults for the free extent fit table
package feft_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_BEST   = 2'd1;
  localparam logic [1:0] ACT_WORST  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] pos;
    logic [15:0] size;
  } extent_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] extent_position;
    logic [15:0] extent_size;
    logic [15:0] request_size;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] taken_position;
    logic [15:0] taken_size;
    logic [6:0]  entries_held;
  } res_t;

endpackage

// ----- rtl/feft_if.sv -----
// request and result channel interfaces
interface feft_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] extent_position;
  logic [15:0] extent_size;
  logic [15:0] request_size;

  modport source (output valid, action, extent_position, extent_size, request_size,
                  input ready);
  modport sink (input valid, action, extent_position, extent_size, request_size,
                output ready);
endinterface

interface feft_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] taken_position;
  logic [15:0] taken_size;
  logic [6:0]  entries_held;

  modport source (output valid, status, taken_position, taken_size, entries_held,
                  input ready);
  modport sink (input valid, status, taken_position, taken_size, entries_held,
                output ready);
endinterface

// ----- rtl/feft_mem.sv -----
// extent store, one write port and one registered read port
module feft_mem #(
  parameter int TABLE_DEPTH = feft_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output feft_pkg::extent_t  rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  feft_pkg::extent_t  wr_data
);

  feft_pkg::extent_t store [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

// ----- rtl/feft_seq.sv -----
// sequencer that walks the sorted store for insert, best fit and worst fit
module feft_seq #(
  parameter int TABLE_DEPTH = feft_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  feft_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               res_valid,
  output feft_pkg::res_t     res,
  input  logic               res_room,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  feft_pkg::extent_t  rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output feft_pkg::extent_t  wr_data
);

  typedef enum logic [2:0] {IDLE, RD, CMP, PUT, FIN} state_t;

  state_t           state;
  logic [AW-1:0]    k;
  logic [AW-1:0]    put_idx;
  logic [CW-1:0]    count;
  feft_pkg::cmd_t   op;
  logic             found;
  logic [1:0]       status;
  logic [31:0]      take_pos;
  logic [15:0]      take_size;
  logic             at_last;
  logic             fits;
  logic             covers;

  assign at_last = (CW'(k) == count - CW'(1));
  assign fits    = (rd_data.size >= op.request_size);
  assign covers  = (rd_data.size >= op.extent_size);

  assign busy      = (state != IDLE);
  assign res_valid = (state == FIN);
  assign res.status         = status;
  assign res.taken_position = take_pos;
  assign res.taken_size     = take_size;
  assign res.entries_held   = 7'(count);

  assign rd_en   = (state == RD);
  assign rd_addr = k;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = put_idx;
    wr_data = '{pos: op.extent_position, size: op.extent_size};
    case (state)
      PUT: begin
        wr_en = 1'b1;
      end
      CMP: begin
        wr_data = rd_data;
        if (op.action == feft_pkg::ACT_INSERT && covers) begin
          wr_en   = 1'b1;
          wr_addr = k + AW'(1);
        end else if (op.action == feft_pkg::ACT_BEST && found) begin
          wr_en   = 1'b1;
          wr_addr = k - AW'(1);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            op        <= cmd;
            found     <= 1'b0;
            take_pos  <= '0;
            take_size <= '0;
            put_idx   <= '0;
            case (cmd.action)
              feft_pkg::ACT_INSERT: begin
                if (count == CW'(TABLE_DEPTH)) begin
                  status <= feft_pkg::ST_FULL;
                  state  <= FIN;
                end else if (count == '0) begin
                  status <= feft_pkg::ST_DONE;
                  state  <= PUT;
                end else begin
                  status <= feft_pkg::ST_DONE;
                  k      <= AW'(count - CW'(1));
                  state  <= RD;
                end
              end
              feft_pkg::ACT_BEST: begin
                if (count == '0) begin
                  status <= feft_pkg::ST_NOFIT;
                  state  <= FIN;
                end else begin
                  status <= feft_pkg::ST_DONE;
                  k      <= '0;
                  state  <= RD;
                end
              end
              feft_pkg::ACT_WORST: begin
                if (count == '0) begin
                  status <= feft_pkg::ST_NOFIT;
                  state  <= FIN;
                end else begin
                  status <= feft_pkg::ST_DONE;
                  k      <= AW'(count - CW'(1));
                  state  <= RD;
                end
              end
              default: begin
                status <= feft_pkg::ST_DONE;
                state  <= FIN;
              end
            endcase
          end
        end
        RD: begin
          state <= CMP;
        end
        CMP: begin
          case (op.action)
            feft_pkg::ACT_INSERT: begin
              if (covers) begin
                if (k == '0) begin
                  put_idx <= '0;
                  state   <= PUT;
                end else begin
                  k     <= k - AW'(1);
                  state <= RD;
                end
              end else begin
                put_idx <= k + AW'(1);
                state   <= PUT;
              end
            end
            feft_pkg::ACT_BEST: begin
              if (!found && fits) begin
                found     <= 1'b1;
                take_pos  <= rd_data.pos;
                take_size <= rd_data.size;
              end
              if (at_last) begin
                if (found || fits) begin
                  count <= count - CW'(1);
                end else begin
                  status <= feft_pkg::ST_NOFIT;
                end
                state <= FIN;
              end else begin
                k     <= k + AW'(1);
                state <= RD;
              end
            end
            default: begin
              if (fits) begin
                take_pos  <= rd_data.pos;
                take_size <= rd_data.size;
                count     <= count - CW'(1);
              end else begin
                status <= feft_pkg::ST_NOFIT;
              end
              state <= FIN;
            end
          endcase
        end
        PUT: begin
          count <= count + CW'(1);
          state <= FIN;
        end
        FIN: begin
          if (res_room) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/free_extent_fit_table_top.sv -----
// free extent table kept sorted by size, with insert, best-fit and worst-fit take
// insert walks down from the top, moving entries at least as large up a place;
// best fit walks up, takes the first that fits and moves later entries down;
// worst fit reads only the largest entry; other actions leave the table as is
// one transfer is walked at a time; a stalled result holds the input
// reset: synchronous, empties the table; the store itself is not cleared
module free_extent_fit_table_top #(
  parameter int TABLE_DEPTH = feft_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input logic        clk,
  input logic        rst,
  feft_in_if.sink    in_ch,
  feft_out_if.source out_ch
);

  feft_pkg::cmd_t     cmd;
  feft_pkg::res_t     res;
  feft_pkg::res_t     res_q;
  feft_pkg::extent_t  rd_data;
  feft_pkg::extent_t  wr_data;
  logic               busy;
  logic               start;
  logic               res_valid;
  logic               res_room;
  logic               out_valid;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;

  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && !busy;
  assign cmd.action          = in_ch.action;
  assign cmd.extent_position = in_ch.extent_position;
  assign cmd.extent_size     = in_ch.extent_size;
  assign cmd.request_size    = in_ch.request_size;

  assign res_room = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_room) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_room && res_valid) begin
      res_q <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = res_q.status;
  assign out_ch.taken_position = res_q.taken_position;
  assign out_ch.taken_size     = res_q.taken_size;
  assign out_ch.entries_held   = res_q.entries_held;

  feft_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  feft_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
